[hw/rtl/magnetic_current_sensor_calibration_defines.svh]
// Assertion macros shared by the magnetic current sensor calibration RTL.
`ifndef MAGNETIC_CURRENT_SENSOR_CALIBRATION_DEFINES_SVH
`define MAGNETIC_CURRENT_SENSOR_CALIBRATION_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Clocked check, disabled while reset is high.
`define MCSC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked check that also holds during reset.
`define MCSC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MCSC_ASSERT(lbl, clk, rst, prop, msg)
`define MCSC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[hw/rtl/mcsc_pkg.sv]
// Shared types and constants of the magnetic current sensor calibration block.
`timescale 1ns / 1ps
package mcsc_pkg;

  localparam int DIVISOR_W = 31;
  localparam int TILT_W    = 16;
  localparam int CAL_N_W   = 12;
  localparam int CFG_IDX_W = 2;
  localparam int CURRENT_W = 32;

  localparam logic [DIVISOR_W-1:0] DIVISOR_RESET = 31'd20908800;
  localparam logic [TILT_W-1:0]    TILT_RESET    = 16'd1000;
  localparam logic [CAL_N_W-1:0]   CAL_N_RESET   = 12'd220;

  localparam logic [CURRENT_W-1:0] CURRENT_MAX = 32'h7FFF_FFFF;
  localparam logic [CURRENT_W-1:0] CURRENT_MIN = 32'h8000_0000;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIVISOR = 2'd0,
    REG_TILT    = 2'd1,
    REG_CAL_N   = 2'd2
  } cfg_reg_t;

  // item kinds carried in tuser
  typedef enum logic [1:0] {
    MODE_MAG   = 2'd0,
    MODE_ACCEL = 2'd1,
    MODE_CAL   = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    CAL_NONE    = 2'd0,
    CAL_ONGOING = 2'd1,
    CAL_DONE    = 2'd2
  } cal_state_t;

  typedef struct packed {
    logic capture;    // latch the input beat
    logic div_start;  // load operands into the divider
    logic commit;     // update state, which is also the output payload
  } mcsc_cmd_t;

  typedef struct packed {
    logic is_sample;  // latched beat is a magnetometer sample
    logic div_busy;
    logic div_done;
  } mcsc_sts_t;

endpackage

[hw/rtl/mcsc_divider.sv]
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module mcsc_divider #(
  parameter int DVD_W = 49,
  parameter int DVS_W = 31
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dvd;   // shifts out dividend bits, shifts in quotient bits
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;

  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   trial_sub;
  logic             fits;
  logic [DVS_W-1:0] rem_next;

  assign trial     = {rem, dvd[DVD_W-1]};
  assign trial_sub = trial - {1'b0, dvs};
  assign fits      = !trial_sub[DVS_W];
  assign rem_next  = fits ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
  assign quotient  = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[DVD_W-2:0], fits};
      rem <= rem_next;
    end
  end

endmodule

[hw/rtl/mcsc_datapath.sv]
// Datapath: configuration, calibration state, offset and current arithmetic.
`timescale 1ns / 1ps
module mcsc_datapath
  import mcsc_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16,
  parameter int COUNT_WIDTH  = 12
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [DIVISOR_W-1:0]           cfg_data,
  input  logic [1:0]                     mode,
  input  logic signed [SAMPLE_WIDTH-1:0] field_z,
  input  logic signed [SAMPLE_WIDTH-1:0] accel_x,
  input  logic signed [SAMPLE_WIDTH-1:0] accel_y,
  input  mcsc_cmd_t                      cmd,
  output mcsc_sts_t                      sts,
  output logic [1:0]                     status,
  output logic [CURRENT_W-1:0]           current_q32
);

  localparam int OW    = SAMPLE_WIDTH + 1;   // offset
  localparam int DW    = SAMPLE_WIDTH + 2;   // z - offset
  localparam int MW    = SAMPLE_WIDTH + 1;   // magnitudes
  localparam int DVD_W = MW + CURRENT_W;
  localparam int CW    = (COUNT_WIDTH > CAL_N_W) ? COUNT_WIDTH : CAL_N_W;
  localparam int TW    = (MW > TILT_W) ? MW : TILT_W;

  logic [DIVISOR_W-1:0] divisor_reg;
  logic [TILT_W-1:0]    tilt_reg;
  logic [CAL_N_W-1:0]   cal_n_reg;

  cal_state_t                cal_state;
  logic [COUNT_WIDTH-1:0]    sample_count;
  logic signed [OW-1:0]      offset_z;
  logic [CURRENT_W-1:0]      current_value;

  logic [1:0]                     mode_q;
  logic signed [SAMPLE_WIDTH-1:0] z_q;
  logic signed [SAMPLE_WIDTH-1:0] x_q;
  logic signed [SAMPLE_WIDTH-1:0] y_q;

  logic [CAL_N_W-1:0]   nsamp;
  logic [DIVISOR_W-1:0] div_d;
  logic                 ongoing;

  logic signed [DW-1:0] z_ext;
  logic signed [DW-1:0] x_ext;
  logic signed [DW-1:0] y_ext;
  logic signed [DW-1:0] diff;
  logic                 diff_neg;
  logic                 z_neg;
  logic [MW-1:0]        diff_mag;
  logic [MW-1:0]        z_mag;
  logic [MW-1:0]        x_mag;
  logic [MW-1:0]        y_mag;
  logic                 tilted;

  logic [DVD_W-1:0]     dividend;
  logic [DIVISOR_W-1:0] divisor;
  logic [DVD_W-1:0]     quo;

  logic [MW-1:0]          q_low;
  logic signed [MW-1:0]   z_quo;
  logic signed [DW-1:0]   off_sum;
  logic signed [OW-1:0]   off_sat;
  logic [COUNT_WIDTH-1:0] count_inc;
  logic                   count_hit;
  logic                   ge_half;
  logic                   gt_half;
  logic [CURRENT_W-1:0]   cur_sat;

  assign nsamp   = (cal_n_reg == '0) ? CAL_N_W'(1) : cal_n_reg;
  assign div_d   = (divisor_reg == '0) ? DIVISOR_W'(1) : divisor_reg;
  assign ongoing = (cal_state == CAL_ONGOING);

  assign z_ext    = DW'(z_q);
  assign x_ext    = DW'(x_q);
  assign y_ext    = DW'(y_q);
  assign diff     = z_ext - DW'(offset_z);
  assign diff_neg = diff[DW-1];
  assign z_neg    = z_q[SAMPLE_WIDTH-1];
  assign diff_mag = diff_neg ? MW'(-diff) : MW'(diff);
  assign z_mag    = z_neg ? MW'(-z_ext) : MW'(z_ext);
  assign x_mag    = x_q[SAMPLE_WIDTH-1] ? MW'(-x_ext) : MW'(x_ext);
  assign y_mag    = y_q[SAMPLE_WIDTH-1] ? MW'(-y_ext) : MW'(y_ext);
  assign tilted   = (TW'(x_mag) > TW'(tilt_reg)) || (TW'(y_mag) > TW'(tilt_reg));

  // ongoing: |z| / N ; otherwise |z - offset| * 2^32 / D
  assign dividend = ongoing ? DVD_W'(z_mag) : {diff_mag, {CURRENT_W{1'b0}}};
  assign divisor  = ongoing ? DIVISOR_W'(nsamp) : div_d;

  mcsc_divider #(
    .DVD_W (DVD_W),
    .DVS_W (DIVISOR_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .busy     (sts.div_busy),
    .done     (sts.div_done),
    .quotient (quo)
  );

  assign sts.is_sample = (mode_q == MODE_MAG);

  // offset accumulate with truncation toward zero and saturation
  assign q_low   = quo[MW-1:0];
  assign z_quo   = z_neg ? MW'(-q_low) : q_low;
  assign off_sum = DW'(offset_z) + DW'(z_quo);
  always_comb begin
    if (off_sum[DW-1] != off_sum[DW-2]) begin
      off_sat = off_sum[DW-1] ? {1'b1, {SAMPLE_WIDTH{1'b0}}} : {1'b0, {SAMPLE_WIDTH{1'b1}}};
    end else begin
      off_sat = off_sum[OW-1:0];
    end
  end

  assign count_inc = sample_count + 1'b1;
  assign count_hit = (CW'(count_inc) == CW'(nsamp));

  // the current is the negated quotient, so its sign is opposite to that of diff
  assign ge_half = |quo[DVD_W-1:CURRENT_W-1];
  assign gt_half = (|quo[DVD_W-1:CURRENT_W]) || (quo[CURRENT_W-1] && (|quo[CURRENT_W-2:0]));
  always_comb begin
    if (diff_neg) begin
      cur_sat = ge_half ? CURRENT_MAX : quo[CURRENT_W-1:0];
    end else begin
      cur_sat = gt_half ? CURRENT_MIN : -quo[CURRENT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      divisor_reg <= DIVISOR_RESET;
      tilt_reg    <= TILT_RESET;
      cal_n_reg   <= CAL_N_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DIVISOR: divisor_reg <= cfg_data;
        REG_TILT:    tilt_reg    <= cfg_data[TILT_W-1:0];
        REG_CAL_N:   cal_n_reg   <= cfg_data[CAL_N_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_q <= mode;
      z_q    <= field_z;
      x_q    <= accel_x;
      y_q    <= accel_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_state     <= CAL_NONE;
      sample_count  <= '0;
      offset_z      <= '0;
      current_value <= '0;
    end else if (cmd.commit) begin
      case (mode_q)
        MODE_MAG: begin
          if (ongoing) begin
            offset_z     <= off_sat;
            sample_count <= count_inc;
            if (count_hit) begin
              cal_state <= CAL_DONE;
            end
          end else begin
            current_value <= cur_sat;
          end
        end
        MODE_ACCEL: begin
          if (tilted) begin
            cal_state <= CAL_NONE;
          end
        end
        MODE_CAL: begin
          offset_z     <= '0;
          sample_count <= '0;
          cal_state    <= CAL_ONGOING;
        end
        default: ;
      endcase
    end
  end

  assign status      = cal_state;
  assign current_q32 = current_value;

endmodule

[hw/rtl/mcsc_ctrl.sv]
// Controller: sequences capture, division and commit, owns the handshakes.
`timescale 1ns / 1ps
`include "magnetic_current_sensor_calibration_defines.svh"
module mcsc_ctrl
  import mcsc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  output logic      m_tvalid,
  input  logic      m_tready,
  input  mcsc_sts_t sts,
  output mcsc_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_WRITE
  } ctrl_state_t;

  ctrl_state_t state;
  logic        out_free;

  assign out_free      = !m_tvalid || m_tready;
  assign s_tready      = (state == ST_IDLE);
  assign cmd.capture   = s_tvalid && (state == ST_IDLE);
  assign cmd.div_start = (state == ST_START) && sts.is_sample;
  assign cmd.commit    = (state == ST_WRITE) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_START;
          end
        end
        ST_START: begin
          state <= sts.is_sample ? ST_DIV : ST_WRITE;
        end
        ST_DIV: begin
          if (sts.div_done) begin
            state <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `MCSC_ASSERT(a_commit_when_free, clk, rst, cmd.commit |-> out_free, "commit while output held")
  `MCSC_ASSERT(a_start_idle_div, clk, rst, cmd.div_start |-> !sts.div_busy, "divider restarted")
  `MCSC_ASSERT(a_valid_from_commit, clk, rst, $rose(m_tvalid) |-> $past(cmd.commit), "output without commit")
  `MCSC_ASSERT(a_done_in_div, clk, rst, sts.div_done |-> (state == ST_DIV), "divider done off sequence")

endmodule

[hw/rtl/magnetic_current_sensor_calibration.sv]
// Top level of the magnetic current sensor with zero-field calibration.
//
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+-------------------------------------
//  s_       | in  | s_tvalid / s_tready  | tuser: mode; tdata: z, accel x, y
//  m_       | out | m_tvalid / m_tready  | tdata: status, current_q32
//  cfg_     | in  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Magnetometer beats run through a shared restoring divider, one quotient bit
// per cycle. Accelerometer, calibrate and unused-mode beats skip the divider.
// One beat is in work at a time; a finished result waits in the state
// registers while the next beat is accepted and processed, and only its commit
// stalls until m_tready takes the pending result.
// Reset (rst, synchronous) restores register defaults and clears the state to
// none, count and offset zero, current zero. cfg writes are taken every cycle.
`timescale 1ns / 1ps
module magnetic_current_sensor_calibration
  import mcsc_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16,
  parameter int COUNT_WIDTH  = 12
) (
  input  logic                   clk,
  input  logic                   rst,
  // input stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [1:0]             s_tuser,   // [1:0] mode
  // from bit 0: field_z, accel_x, accel_y (SAMPLE_WIDTH each), zero fill
  input  logic [((3*SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,
  // result stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [39:0]            m_tdata,   // [1:0] status, [33:2] current_q32, zero fill
  // configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [DIVISOR_W-1:0]   cfg_data
);

  localparam int SW = SAMPLE_WIDTH;
  localparam int OUT_PAD = 40 - 2 - CURRENT_W;

  mcsc_cmd_t            cmd;
  mcsc_sts_t            sts;
  logic [1:0]           status;
  logic [CURRENT_W-1:0] current_q32;

  // registers are writable at any time; firmware writes them only while idle
  assign cfg_ready = 1'b1;

  mcsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mcsc_datapath #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mode        (s_tuser),
    .field_z     (s_tdata[SW-1:0]),
    .accel_x     (s_tdata[2*SW-1:SW]),
    .accel_y     (s_tdata[3*SW-1:2*SW]),
    .cmd         (cmd),
    .sts         (sts),
    .status      (status),
    .current_q32 (current_q32)
  );

  // the committed state is the result payload; it holds until the next commit
  assign m_tdata = {{OUT_PAD{1'b0}}, current_q32, status};

endmodule

[verif/magnetic_current_sensor_calibration_tb.sv]
// Self-checking testbench for the magnetic current sensor calibration block.
`timescale 1ns / 1ps
module magnetic_current_sensor_calibration_tb;
  import mcsc_pkg::*;

  // s_tdata: field_z [15:0], accel_x [31:16], accel_y [47:32]
  localparam int S_W = 48;
  // m_tdata: status [1:0], current_q32 [33:2], zero fill
  localparam int M_W = 40;

  // tuser code that the block has no meaning for
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  // register index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

  localparam longint OFFSET_HI = 64'sd65535;
  localparam longint OFFSET_LO = -64'sd65536;
  localparam longint CUR_HI    = 64'sd2147483647;
  localparam longint CUR_LO    = -64'sd2147483648;
  localparam longint Q32_ONE   = 64'sd4294967296;

  localparam int WATCHDOG_LIMIT   = 4000;  // well above the long hold plus one divide
  localparam int SETTLE_CYCLES    = 80;    // longer than one divide
  localparam int LONG_HOLD_CYCLES = 400;

  typedef struct packed {
    cal_state_t           status;
    logic [CURRENT_W-1:0] current;
  } reading_t;

  // Tracks registers and calibration state, and holds the readings still owed.
  class calib_scoreboard;
    logic [DIVISOR_W-1:0] divisor;
    logic [TILT_W-1:0]    tilt;
    logic [CAL_N_W-1:0]   cal_n;
    cal_state_t           state;
    logic [CAL_N_W-1:0]   count;
    longint               offset;
    logic [CURRENT_W-1:0] current;
    reading_t             readings[$];
    int                   mismatches;
    int                   checked;
    int                   tilt_trips;

    function new();
      divisor    = DIVISOR_RESET;
      tilt       = TILT_RESET;
      cal_n      = CAL_N_RESET;
      state      = CAL_NONE;
      count      = '0;
      offset     = 0;
      current    = '0;
      mismatches = 0;
      checked    = 0;
      tilt_trips = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIVISOR_W-1:0] data);
      case (idx)
        REG_DIVISOR: divisor = data;
        REG_TILT:    tilt    = data[TILT_W-1:0];
        REG_CAL_N:   cal_n   = data[CAL_N_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_beat(logic [1:0] mode, logic [S_W-1:0] data);
      longint   z;
      longint   ax;
      longint   ay;
      longint   n;
      longint   d;
      longint   q;
      reading_t r;
      z  = longint'($signed(data[15:0]));
      ax = longint'($signed(data[31:16]));
      ay = longint'($signed(data[47:32]));
      n  = (cal_n == 0) ? 64'sd1 : longint'(cal_n);
      case (mode)
        MODE_MAG: begin
          if (state == CAL_ONGOING) begin
            // averaging: each sample adds its share, truncated toward zero
            offset = offset + z / n;
            if (offset > OFFSET_HI) offset = OFFSET_HI;
            if (offset < OFFSET_LO) offset = OFFSET_LO;
            count = count + 1'b1;
            if (longint'(count) == n) state = CAL_DONE;
          end else begin
            d = (divisor == 0) ? 64'sd1 : longint'(divisor);
            q = -(((z - offset) * Q32_ONE) / d);
            if (q > CUR_HI) q = CUR_HI;
            if (q < CUR_LO) q = CUR_LO;
            current = q[CURRENT_W-1:0];
          end
        end
        MODE_ACCEL: begin
          if (ax < 0) ax = -ax;
          if (ay < 0) ay = -ay;
          if (ax > longint'(tilt) || ay > longint'(tilt)) begin
            if (state != CAL_NONE) tilt_trips++;
            state = CAL_NONE;
          end
        end
        MODE_CAL: begin
          offset = 0;
          count  = '0;
          state  = CAL_ONGOING;
        end
        default: ;
      endcase
      r.status  = state;
      r.current = current;
      readings.push_back(r);
    endfunction

    function void check_beat(logic [M_W-1:0] data);
      reading_t             want;
      logic [1:0]           got_status;
      logic [CURRENT_W-1:0] got_current;
      got_status  = data[1:0];
      got_current = data[33:2];
      if (readings.size() == 0) begin
        $display("%0t: unexpected result beat: status %0d current %0d", $time,
                 got_status, $signed(got_current));
        mismatches++;
        return;
      end
      want = readings.pop_front();
      checked++;
      if (got_status !== want.status) begin
        $display("%0t: status mismatch: expected %0d, actual %0d", $time,
                 want.status, got_status);
        mismatches++;
      end
      if (got_current !== want.current) begin
        $display("%0t: current_q32 mismatch: expected %0d, actual %0d", $time,
                 $signed(want.current), $signed(got_current));
        mismatches++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [1:0]           s_tuser;
  logic [S_W-1:0]       s_tdata;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_W-1:0]       m_tdata;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIVISOR_W-1:0] cfg_data;

  calib_scoreboard sb;

  // stimulus-side copies of the settings, used to aim samples and tilt values
  int   cur_cal_n;
  int   cur_tilt;
  // last part of the run: no idling on either side
  logic steady;
  // set by the stimulus, consumed by the receiver to start one long hold-off
  logic long_hold_req;
  int   beats_sent;
  int   cal_cmds;
  int   settings_applied;
  int   quiet_cycles;

  magnetic_current_sensor_calibration dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Monitor and watchdog: every accepted beat is handled at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_beat(m_tdata);
      if (s_tvalid && s_tready) sb.note_beat(s_tuser, s_tdata);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("%0t: timeout, no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
          $display("*** FAILED ***");
          $finish;
        end
      end
    end
  end

  // Result sink: random stall bursts, plus one long hold-off on request so
  // the block backs up with a result pending and stops taking input.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        m_tready <= 1'b1;
      end else if (!steady && $urandom_range(0, 99) < 20) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  function automatic logic [15:0] rand16();
    return 16'($urandom);
  endfunction

  // z readings: half full scale, half close to zero so averages stay small
  function automatic logic [15:0] rand_z();
    logic [15:0] v;
    if ($urandom_range(0, 1) == 0) v = 16'($urandom);
    else v = 16'($urandom_range(0, 600)) - 16'd300;
    return v;
  endfunction

  // accel values on and around the tilt limit, plus small and full-range random ones
  function automatic logic [15:0] near_tilt();
    int v;
    case ($urandom_range(0, 6))
      0: v = cur_tilt;
      1: v = cur_tilt + 1;
      2: v = -cur_tilt;
      3: v = -(cur_tilt + 1);
      4: v = cur_tilt - 1;
      5: v = $urandom_range(0, 200) - 100;
      default: v = $urandom;
    endcase
    return v[15:0];
  endfunction

  // One input beat; fields the mode does not use are filled at random.
  task automatic send_beat(logic [1:0] mode, logic [15:0] z, logic [15:0] x,
                           logic [15:0] y);
    int gap;
    @(negedge clk);
    if (!steady && $urandom_range(0, 99) < 15) begin
      gap = $urandom_range(1, 5);
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {y, x, z};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_mag(logic [15:0] z);
    send_beat(MODE_MAG, z, rand16(), rand16());
  endtask

  task automatic send_accel(logic [15:0] x, logic [15:0] y);
    send_beat(MODE_ACCEL, rand16(), x, y);
  endtask

  task automatic send_cal();
    send_beat(MODE_CAL, rand16(), rand16(), rand16());
    cal_cmds++;
  endtask

  task automatic send_unused();
    send_beat(MODE_UNUSED, rand16(), rand16(), rand16());
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIVISOR_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stop offering input, wait for every owed reading, then let the block go idle.
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(logic [DIVISOR_W-1:0] d, logic [DIVISOR_W-1:0] t,
                            logic [DIVISOR_W-1:0] n);
    settle();
    write_reg(REG_DIVISOR, d);
    write_reg(REG_TILT, t);
    write_reg(REG_CAL_N, n);
    cur_tilt  = int'(t[TILT_W-1:0]);
    cur_cal_n = (n[CAL_N_W-1:0] == 0) ? 1 : int'(n[CAL_N_W-1:0]);
    settings_applied++;
  endtask

  // Mostly complete calibrations followed by readings, mixed with tilt
  // checks, cut-short calibrations and unused-mode beats.
  task automatic random_stretch(int beats);
    int done_beats;
    int k;
    int pick;
    done_beats = 0;
    while (done_beats < beats) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        send_cal();
        done_beats++;
        k = ($urandom_range(0, 99) < 80) ? cur_cal_n : $urandom_range(0, cur_cal_n + 2);
        for (int i = 0; i < k; i++) begin
          if ($urandom_range(0, 99) < 5) begin
            send_accel(near_tilt(), near_tilt());
            done_beats++;
          end
          send_mag(rand_z());
          done_beats++;
        end
      end else if (pick < 65) begin
        k = $urandom_range(1, 4);
        repeat (k) begin
          send_mag(rand_z());
          done_beats++;
        end
      end else if (pick < 88) begin
        send_accel(near_tilt(), near_tilt());
        done_beats++;
      end else begin
        send_unused();  // changes nothing, not counted
      end
    end
  endtask

  initial begin
    rst              = 1'b1;
    s_tvalid         = 1'b0;
    s_tuser          = '0;
    s_tdata          = '0;
    cfg_valid        = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    steady           = 1'b0;
    long_hold_req    = 1'b0;
    beats_sent       = 0;
    cal_cmds         = 0;
    settings_applied = 0;
    quiet_cycles     = 0;
    cur_cal_n        = int'(CAL_N_RESET);
    cur_tilt         = int'(TILT_RESET);
    sb               = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Uncalibrated readings at reset settings: zero and both full-scale ends,
    // then the most negative acceleration.
    send_mag(16'h0000);
    send_mag(16'h7FFF);
    send_mag(16'h8000);
    send_accel(16'h8000, 16'h0000);

    // Unit divisor so readings saturate both ways; two-sample calibration.
    set_config(31'd1, 31'd1000, 31'd2);
    send_cal();
    send_unused();                     // unused mode while ongoing
    send_accel(16'd1000, 16'hFC18);    // exactly on the limit: no trip
    send_mag(16'h7FFF);
    send_mag(16'h7FFF);                // reaches N: done
    send_mag(16'h8000);                // saturates high
    send_mag(16'h7FFF);                // saturates low
    send_accel(16'h0000, 16'd1001);    // one above the limit: back to none

    // Tilt limit of 32768: even -32768 on both axes does not trip.
    set_config(DIVISOR_RESET, 31'd32768, 31'd3);
    send_cal();
    send_mag(16'h7FFF);
    send_mag(16'h7FFF);
    send_accel(16'h8000, 16'h8000);

    // N drops below the running count: calibration keeps going and the
    // offset runs into both rails. Divisor zero is taken as one.
    set_config(31'd0, 31'd32767, 31'd1);
    send_mag(16'h7FFF);
    send_mag(16'h7FFF);                // offset at its upper rail
    repeat (4) send_mag(16'h8000);     // down to the lower rail
    send_accel(16'h7FFF, 16'h7FFF);
    send_accel(16'h8000, 16'h0000);    // |-32768| trips a 32767 limit
    send_mag(16'h7FFF);
    send_mag(16'h8000);

    // Largest N, then N lowered mid-run below the count: the count runs past
    // the new N and the calibration stays ongoing.
    set_config(31'($urandom_range(1, 32'h7FFF_FFFF)), 31'd65535, 31'd4095);
    write_reg(REG_NONE, 31'($urandom));
    send_cal();
    repeat (10) send_mag(16'($urandom_range(0, 600)) - 16'd300);
    set_config(31'($urandom_range(1, 32'h7FFF_FFFF)), 31'($urandom_range(0, 32768)), 31'd5);
    repeat (20) send_mag(16'($urandom_range(0, 600)) - 16'd300);

    // Random part over several settings, extremes included.
    set_config(31'd1, 31'd1000, 31'd4);
    random_stretch(100);
    set_config(31'h7FFF_FFFF, 31'd0, 31'd1);
    long_hold_req = 1'b1;
    random_stretch(100);
    set_config(31'd0, 31'd32768, 31'd7);
    random_stretch(100);
    // high bits above the register width are written too and must be dropped
    set_config(31'($urandom_range(1, 32'h7FFF_FFFF)), 31'($urandom),
               {19'($urandom), 12'd0});
    random_stretch(100);
    set_config(DIVISOR_RESET, TILT_RESET, 31'd3);
    random_stretch(100);
    set_config(31'($urandom_range(1, 1000)), 31'($urandom_range(0, 32768)),
               31'($urandom_range(1, 16)));
    random_stretch(100);
    set_config(31'($urandom), 31'($urandom_range(32000, 32768)),
               {19'($urandom), 12'($urandom_range(1, 10))});
    random_stretch(100);
    set_config(31'($urandom), 31'($urandom_range(0, 32768)), 31'($urandom_range(1, 8)));
    steady = 1'b1;
    random_stretch(130);

    settle();
    $display("Run covered %0d input beats, %0d calibrate commands and %0d tilt trips",
             beats_sent, cal_cmds, sb.tilt_trips);
    $display("over %0d register settings; %0d result beats compared, %0d mismatches.",
             settings_applied, sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.readings.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[magnetic_current_sensor_calibration.f]
+incdir+hw/rtl
hw/rtl/mcsc_pkg.sv
hw/rtl/mcsc_divider.sv
hw/rtl/mcsc_datapath.sv
hw/rtl/mcsc_ctrl.sv
hw/rtl/magnetic_current_sensor_calibration.sv
verif/magnetic_current_sensor_calibration_tb.sv
